@@ sv/pvsb_pkg.sv @@
// Shared types, widths and register codes of the packed video-memory sprite blitter.
`default_nettype none
package pvsb_pkg;

  // fixed field widths
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DW    = 12;
  localparam int COL_W     = 11;
  localparam int LEN_W     = 12;
  localparam int OX_W      = 11;
  localparam int OY_W      = 8;
  localparam int PG_W      = 4;
  localparam int PIX_W     = 8;
  localparam int RADDR_W   = 18;
  localparam int BCOL_W    = 12;
  localparam int DROW_W    = 12;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROTATE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_LEN    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PAGE_COLS  = 3'd5;

  // word operation codes
  localparam logic OP_PLOT = 1'b0;
  localparam logic OP_READ = 1'b1;

  // pixel depth codes
  localparam logic DEPTH_4BPP = 1'b0;
  localparam logic DEPTH_8BPP = 1'b1;

  localparam logic [LEN_W-1:0] MAX_LEN     = 12'd2048;
  localparam logic [PG_W-1:0]  PAGES_RESET = 4'd8;
  localparam logic [LEN_W-1:0] LEN_RESET   = 12'd1;
  localparam logic [7:0]       NIB_LO_MASK = 8'h0f;
  localparam logic [7:0]       NIB_HI_MASK = 8'hf0;
  localparam logic [3:0]       NIB_MASK    = 4'hf;
  localparam int               PAGE_BYTES  = 128;
  localparam int               PAGE_SHIFT  = 7;

  typedef struct packed {
    logic             depth_mode;
    logic             rotate;
    logic [OX_W-1:0]  origin_x;
    logic [OY_W-1:0]  origin_y;
    logic [LEN_W-1:0] row_len;
    logic [PG_W-1:0]  page_cols;
  } cfg_t;

  // destination of one source pixel, before the memory bounds check
  typedef struct packed {
    logic              drop;
    logic              high;
    logic [BCOL_W-1:0] bytecol;
    logic [DROW_W-1:0] row;
  } place_t;

endpackage
`default_nettype wire

@@ sv/pvsb_vram.sv @@
// Byte-wide video memory: one write port, one registered read port.
`default_nettype none
module pvsb_vram #(
  parameter int DEPTH = 262144,
  parameter int AW    = 18
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output      logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ sv/pvsb_place.sv @@
// Source position counter and destination placement of each plotted pixel.
`default_nettype none
module pvsb_place (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire pvsb_pkg::cfg_t  cfg,
  input  wire logic            plot_acc,
  input  wire logic            restart,
  output      pvsb_pkg::place_t place
);
  import pvsb_pkg::*;

  logic [COL_W-1:0] col_r, col_nxt;
  logic [COL_W-1:0] row_r, row_nxt;
  logic [COL_W-1:0] col_cur, row_cur;
  logic [LEN_W-1:0] len;
  logic [LEN_W-1:0] col_inc;
  logic [LEN_W-1:0] dcol, drow;
  logic [LEN_W-1:0] xsum;

  always_comb begin
    // clamp row length to 1..2048
    if (cfg.row_len == '0) begin
      len = LEN_W'(1);
    end else if (cfg.row_len > MAX_LEN) begin
      len = MAX_LEN;
    end else begin
      len = cfg.row_len;
    end

    col_cur = restart ? '0 : col_r;
    row_cur = restart ? '0 : row_r;

    place.drop = 1'b0;
    if (cfg.rotate) begin
      place.drop = ({1'b0, col_cur} >= len);
      dcol = {1'b0, row_cur};
      drow = len - LEN_W'(1) - {1'b0, col_cur};
    end else begin
      dcol = {1'b0, col_cur};
      drow = {1'b0, row_cur};
    end

    if (cfg.depth_mode == DEPTH_8BPP) begin
      xsum          = {2'b00, cfg.origin_x[OX_W-1:1]} + dcol;
      place.bytecol = xsum;
      place.high    = 1'b0;
    end else begin
      xsum          = {1'b0, cfg.origin_x} + dcol;
      place.bytecol = {1'b0, xsum[LEN_W-1:1]};
      place.high    = xsum[0];
    end
    place.row = {4'b0000, cfg.origin_y} + drow;

    // advance the column, wrap into the next row at the row length
    col_inc = {1'b0, col_cur} + LEN_W'(1);
    if (col_inc >= len) begin
      col_nxt = '0;
      row_nxt = row_cur + COL_W'(1);
    end else begin
      col_nxt = col_inc[COL_W-1:0];
      row_nxt = row_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (plot_acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule
`default_nettype wire

@@ sv/packed_vram_sprite_blitter.sv @@
// Top level of the packed video-memory sprite blitter.
// A read word passes the S1, S2 and output registers before it is shown on out_valid.
// Throughput: one word per cycle, plot or read, unless stalled; the memory takes one read and one write a cycle.
// A stalled read result holds the pipeline only while the output register is full.
// Reset: rst_n (synchronous) clears config and position, then a clearing pass writes zero
// to all MAX_ROW_BYTES * MEMORY_ROWS bytes, one a cycle, with in_ready held low.
`default_nettype none
module packed_vram_sprite_blitter #(
  parameter int MAX_ROW_BYTES = 1024,
  parameter int MEMORY_ROWS   = 256
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // configuration write port
  input  wire logic                             cfg_we,
  input  wire logic [pvsb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [pvsb_pkg::CFG_DW-1:0]      cfg_wdata,
  // input words
  input  wire logic                             in_valid,
  output      logic                             in_ready,
  input  wire logic                             in_mode,
  input  wire logic                             in_restart,
  input  wire logic [pvsb_pkg::PIX_W-1:0]       in_pixel,
  input  wire logic [pvsb_pkg::RADDR_W-1:0]     in_read_address,
  // result words
  output      logic                             out_valid,
  input  wire logic                             out_ready,
  output      logic [7:0]                       out_read_data
);
  import pvsb_pkg::*;

  localparam int MEM_DEPTH = MAX_ROW_BYTES * MEMORY_ROWS;
  localparam int AW        = $clog2(MEM_DEPTH);
  localparam int MAXP      = MAX_ROW_BYTES / PAGE_BYTES;
  localparam int PGC_W     = $clog2(MAXP + 1);
  localparam int ROW_W     = $clog2(MEMORY_ROWS);
  localparam int FULL_W    = ROW_W + PGC_W + PAGE_SHIFT + 1;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.depth_mode <= DEPTH_4BPP;
      cfg_r.rotate     <= 1'b0;
      cfg_r.origin_x   <= '0;
      cfg_r.origin_y   <= '0;
      cfg_r.row_len    <= LEN_RESET;
      cfg_r.page_cols  <= PAGES_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEPTH_MODE: cfg_r.depth_mode <= cfg_wdata[0];
        REG_ROTATE:     cfg_r.rotate     <= cfg_wdata[0];
        REG_ORIGIN_X:   cfg_r.origin_x   <= cfg_wdata[OX_W-1:0];
        REG_ORIGIN_Y:   cfg_r.origin_y   <= cfg_wdata[OY_W-1:0];
        REG_ROW_LEN:    cfg_r.row_len    <= cfg_wdata[LEN_W-1:0];
        REG_PAGE_COLS:  cfg_r.page_cols  <= cfg_wdata[PG_W-1:0];
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

  // Clamp the page count to 1..MAXP; the row stride is pages * 128 bytes.
  logic [PGC_W-1:0]  pages;
  logic [BCOL_W-1:0] stride;

  always_comb begin
    if (cfg_r.page_cols == '0) begin
      pages = PGC_W'(1);
    end else if (int'(cfg_r.page_cols) > MAXP) begin
      pages = PGC_W'(MAXP);
    end else begin
      pages = PGC_W'(cfg_r.page_cols);
    end
    stride = BCOL_W'({pages, {PAGE_SHIFT{1'b0}}});
  end

  // ---------------------------------------------------------------------------
  // Clearing pass after reset
  // ---------------------------------------------------------------------------
  logic          clr_busy_r;
  logic [AW-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + AW'(1);
      if (int'(clr_addr_r) == MEM_DEPTH - 1) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control
  // S1: placement registered, address formed, memory read issued.
  // S2: read data back, forward the last write, merge and write back.
  // ---------------------------------------------------------------------------
  logic s1_valid_r, s2_valid_r, out_valid_r;
  logic s2_op_r;
  logic adv;
  logic in_acc;

  // Only a read word parked in S2 behind a full output register can stall.
  assign adv      = !(s2_valid_r && (s2_op_r == OP_READ) && out_valid_r && !out_ready);
  assign in_ready = !clr_busy_r && adv;
  assign in_acc   = in_valid && in_ready;

  // ---------------------------------------------------------------------------
  // Accept stage: source position and destination placement
  // ---------------------------------------------------------------------------
  place_t place;

  pvsb_place u_place (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .plot_acc (in_acc && (in_mode == OP_PLOT)),
    .restart  (in_restart),
    .place    (place)
  );

  // ---------------------------------------------------------------------------
  // S1 registers
  // ---------------------------------------------------------------------------
  logic              s1_op_r;
  place_t            s1_place_r;
  logic              s1_depth_r;
  logic [PIX_W-1:0]  s1_pix_r;
  logic [AW-1:0]     s1_raddr_r;
  logic              s1_oob_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_op_r    <= in_mode;
      s1_place_r <= place;
      s1_depth_r <= cfg_r.depth_mode;
      s1_pix_r   <= in_pixel;
      s1_raddr_r <= AW'(in_read_address);
      s1_oob_r   <= (32'(in_read_address) >= 32'(MEM_DEPTH));
    end
  end

  // Bounds check and byte address of a plotted pixel.
  logic                     s1_in_range;
  logic [ROW_W+PGC_W-1:0]   row_pages;
  logic [FULL_W-1:0]        addr_full;
  logic [AW-1:0]            s1_waddr;
  logic [AW-1:0]            rd_addr;

  always_comb begin
    s1_in_range = (s1_place_r.bytecol < stride)
               && (32'(s1_place_r.row) < 32'(MEMORY_ROWS));
    row_pages   = s1_place_r.row[ROW_W-1:0] * pages;
    addr_full   = {row_pages, {PAGE_SHIFT{1'b0}}} + FULL_W'(s1_place_r.bytecol);
    s1_waddr    = AW'(addr_full);
    rd_addr     = (s1_op_r == OP_READ) ? s1_raddr_r : s1_waddr;
  end

  // ---------------------------------------------------------------------------
  // S2 registers
  // ---------------------------------------------------------------------------
  logic              s2_wen_r;
  logic              s2_high_r;
  logic              s2_depth_r;
  logic [PIX_W-1:0]  s2_pix_r;
  logic [AW-1:0]     s2_addr_r;
  logic              s2_oob_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_op_r    <= s1_op_r;
      s2_wen_r   <= (s1_op_r == OP_PLOT) && !s1_place_r.drop && s1_in_range;
      s2_high_r  <= s1_place_r.high;
      s2_depth_r <= s1_depth_r;
      s2_pix_r   <= s1_pix_r;
      s2_addr_r  <= rd_addr;
      s2_oob_r   <= s1_oob_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Video memory and write-back with forwarding
  // ---------------------------------------------------------------------------
  logic [7:0]    mem_q;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic          plot_we;
  logic [7:0]    old_byte;
  logic [7:0]    new_byte;

  // Most recent plot write; a read issued in the same cycle missed it.
  logic          fwd_valid_r;
  logic [AW-1:0] fwd_addr_r;
  logic [7:0]    fwd_data_r;

  always_comb begin
    plot_we  = s2_valid_r && (s2_op_r == OP_PLOT) && s2_wen_r;
    old_byte = (fwd_valid_r && (fwd_addr_r == s2_addr_r)) ? fwd_data_r : mem_q;

    if (s2_depth_r == DEPTH_8BPP) begin
      new_byte = s2_pix_r;
    end else if (s2_high_r) begin
      new_byte = (old_byte & NIB_LO_MASK) | {s2_pix_r[3:0] & NIB_MASK, 4'h0};
    end else begin
      new_byte = (old_byte & NIB_HI_MASK) | {4'h0, s2_pix_r[3:0] & NIB_MASK};
    end

    // the clearing pass owns the write port until it ends
    mem_we    = clr_busy_r || plot_we;
    mem_waddr = clr_busy_r ? clr_addr_r : s2_addr_r;
    mem_wdata = clr_busy_r ? 8'h00 : new_byte;
  end

  pvsb_vram #(
    .DEPTH (MEM_DEPTH),
    .AW    (AW)
  ) u_vram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (s1_valid_r && adv),
    .raddr (rd_addr),
    .rdata (mem_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_valid_r <= 1'b0;
    end else if (plot_we) begin
      fwd_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (plot_we) begin
      fwd_addr_r <= s2_addr_r;
      fwd_data_r <= new_byte;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic       out_load;
  logic [7:0] out_data_r;

  assign out_load = s2_valid_r && (s2_op_r == OP_READ) && adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= s2_oob_r ? 8'h00 : old_byte;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;

endmodule
`default_nettype wire

@@ sv/pvsb_checker.sv @@
// Port-level checks of the sprite blitter and their binding to the top level.
`default_nettype none
module pvsb_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_ready,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic [7:0]                     out_read_data
);

  // a result word waiting on the consumer holds its data
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_data))
    else $error("result word changed while stalled");

  // reset empties the output register
  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word present after reset");

  // the clearing pass keeps the input closed right after reset
  a_rst_ready: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input accepted during memory clear");

endmodule

bind packed_vram_sprite_blitter pvsb_checker u_pvsb_checker (.*);
`default_nettype wire

@@ bench/tb_packed_vram_sprite_blitter.sv @@
`timescale 1ns / 100ps
// Self-checking bench for the sprite blitter: a directed table, then random sprites and reads.
module tb_packed_vram_sprite_blitter;
  import pvsb_pkg::*;

  localparam int MAX_ROW_BYTES = 1024;
  localparam int MEMORY_ROWS   = 256;
  localparam int MEM_BYTES     = MAX_ROW_BYTES * MEMORY_ROWS;
  localparam int RANDOM_WORDS  = 1100;
  // leave margin after the last read result for plots still in the pipe
  localparam int SETTLE_CYCLES = 6;
  localparam int LONG_HOLD     = 400;
  // the clearing pass after reset alone keeps the input closed while it writes all MEM_BYTES bytes
  localparam int STALL_LIMIT   = 800000;
  localparam int MAX_PRINTS    = 40;

  // receiver stall patterns
  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_THREE_OF_FOUR} rx_style_t;
  // kinds of rows in the directed table
  typedef enum logic [1:0] {STEP_CFG, STEP_PLOT, STEP_READ} step_kind_t;

  typedef struct {
    step_kind_t             kind;
    logic [CFG_IDX_W-1:0]   reg_idx;
    int unsigned            reg_val;
    logic                   restart;
    logic [PIX_W-1:0]       pix;
    logic [RADDR_W-1:0]     addr;
    bit                     known;
    logic [7:0]             want;
  } step_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DW-1:0]    cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_mode = OP_PLOT;
  logic                 in_restart = 1'b0;
  logic [PIX_W-1:0]     in_pixel = '0;
  logic [RADDR_W-1:0]   in_read_address = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [7:0]           out_read_data;

  // predictor state: memory image, source position and register copy
  bit [7:0]             vram_img [MEM_BYTES];
  logic [COL_W-1:0]     src_col = '0;
  logic [COL_W-1:0]     src_row = '0;
  cfg_t                 blit_cfg = '{depth_mode: DEPTH_4BPP, rotate: 1'b0, origin_x: '0,
                                     origin_y: '0, row_len: LEN_RESET, page_cols: PAGES_RESET};
  logic [7:0]           pending_bytes [$];
  logic [RADDR_W-1:0]   recent_writes [$];

  int unsigned          mismatches = 0;
  int unsigned          quiet_cycles = 0;
  int unsigned          burst_left = 0;
  int unsigned          gap_max = 0;
  int unsigned          holds_asked = 0;
  int unsigned          holds_granted = 0;
  bit                   in_flight = 1'b0;

  packed_vram_sprite_blitter #(
    .MAX_ROW_BYTES(MAX_ROW_BYTES),
    .MEMORY_ROWS  (MEMORY_ROWS)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_restart     (in_restart),
    .in_pixel       (in_pixel),
    .in_read_address(in_read_address),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_read_data  (out_read_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Place one source pixel into the memory image, then step the source position.
  function automatic void plot_pixel(input logic restart_f, input logic [PIX_W-1:0] pix);
    int unsigned len, pages, stride, dcol, drow, bytecol, row, addr, nib_x;
    bit hi_nib;
    if (restart_f) begin
      src_col = '0;
      src_row = '0;
    end
    // clamp the row length and page count into their legal ranges
    len = 32'(blit_cfg.row_len);
    if (len < 1) len = 1;
    if (len > MAX_LEN) len = 32'(MAX_LEN);
    pages = 32'(blit_cfg.page_cols);
    if (pages < 1) pages = 1;
    if (pages > MAX_ROW_BYTES / PAGE_BYTES) pages = MAX_ROW_BYTES / PAGE_BYTES;
    stride = pages * PAGE_BYTES;
    hi_nib = 1'b0;
    // a rotated pixel whose column ran past a shrunken row has nowhere to go: drop it
    if (!(blit_cfg.rotate && src_col >= len)) begin
      if (blit_cfg.rotate) begin
        dcol = 32'(src_row);
        drow = len - 1 - src_col;
      end else begin
        dcol = 32'(src_col);
        drow = 32'(src_row);
      end
      if (blit_cfg.depth_mode == DEPTH_8BPP) begin
        bytecol = (blit_cfg.origin_x >> 1) + dcol;
      end else begin
        nib_x   = blit_cfg.origin_x + dcol;
        bytecol = nib_x >> 1;
        hi_nib  = (nib_x & 1) != 0;
      end
      row = blit_cfg.origin_y + drow;
      // drop anything off the right edge or below the last row
      if (bytecol < stride && row < MEMORY_ROWS) begin
        addr = row * stride + bytecol;
        if (blit_cfg.depth_mode == DEPTH_8BPP)
          vram_img[addr] = pix;
        else if (hi_nib)
          vram_img[addr] = (vram_img[addr] & NIB_LO_MASK) | {pix[3:0], 4'h0};
        else
          vram_img[addr] = (vram_img[addr] & NIB_HI_MASK) | {4'h0, pix[3:0]};
        recent_writes.push_back(RADDR_W'(addr));
        if (recent_writes.size() > 32) void'(recent_writes.pop_front());
      end
    end
    // advance the column; wrap to the next row at the row length (row wraps mod 2048)
    if (src_col + 1 >= len) begin
      src_col = '0;
      src_row = src_row + 1'b1;
    end else begin
      src_col = src_col + 1'b1;
    end
  endfunction

  function automatic step_t mk_step(input step_kind_t kind, input logic [CFG_IDX_W-1:0] idx,
                                    input int unsigned val, input logic restart_f,
                                    input logic [PIX_W-1:0] pix, input logic [RADDR_W-1:0] addr,
                                    input bit known, input logic [7:0] want);
    step_t s;
    s.kind    = kind;
    s.reg_idx = idx;
    s.reg_val = val;
    s.restart = restart_f;
    s.pix     = pix;
    s.addr    = addr;
    s.known   = known;
    s.want    = want;
    return s;
  endfunction

  // Read targets: mostly bytes that were written lately, sometimes anywhere.
  function automatic logic [RADDR_W-1:0] pick_read_address();
    if (recent_writes.size() == 0 || $urandom_range(0, 4) == 0)
      return RADDR_W'($urandom_range(0, MEM_BYTES - 1));
    return recent_writes[$urandom_range(0, recent_writes.size() - 1)] ^
           RADDR_W'($urandom_range(0, 1));
  endfunction

  task automatic flag_mismatch(input string what, input logic [7:0] got, input logic [7:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("[%0t] mismatch: %s: got %02h, want %02h", $realtime, what, got, want);
  endtask

  // Offer one word in the current burst pattern; predict it once it is taken.
  task automatic offer_word(input logic mode, input logic restart_f, input logic [PIX_W-1:0] pix,
                            input logic [RADDR_W-1:0] addr, input bit known,
                            input logic [7:0] want);
    if (burst_left == 0) begin
      if (gap_max > 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat ($urandom_range(1, gap_max)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk);
    in_valid        = 1'b1;
    in_mode         = mode;
    in_restart      = restart_f;
    in_pixel        = pix;
    in_read_address = addr;
    // hold the word until the block takes it
    do @(posedge clk); while (!in_ready);
    in_flight = 1'b1;
    if (mode == OP_READ)
      pending_bytes.push_back(known ? want : vram_img[addr]);
    else
      plot_pixel(restart_f, pix);
  endtask

  // Drop valid, wait for every read result, then give the last plots time to land.
  task automatic settle();
    if (in_flight) begin
      @(negedge clk);
      in_valid = 1'b0;
      while (pending_bytes.size() != 0) @(posedge clk);
      repeat (SETTLE_CYCLES) @(posedge clk);
      in_flight = 1'b0;
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = CFG_DW'(val);
    @(posedge clk);
    case (idx)
      REG_DEPTH_MODE: blit_cfg.depth_mode = val[0];
      REG_ROTATE:     blit_cfg.rotate     = val[0];
      REG_ORIGIN_X:   blit_cfg.origin_x   = OX_W'(val);
      REG_ORIGIN_Y:   blit_cfg.origin_y   = OY_W'(val);
      REG_ROW_LEN:    blit_cfg.row_len    = LEN_W'(val);
      REG_PAGE_COLS:  blit_cfg.page_cols  = PG_W'(val);
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Compare each read result with the oldest predicted byte.
  always @(posedge clk) begin : result_check
    logic [7:0] want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_bytes.size() == 0) begin
        flag_mismatch("read result with nothing pending", out_read_data, 8'h00);
      end else begin
        want = pending_bytes.pop_front();
        if (out_read_data !== want) flag_mismatch("read_data", out_read_data, want);
      end
    end
  end

  // End the run when nothing moves for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result side: switch stall patterns now and then; serve long hold requests.
  initial begin : receiver
    rx_style_t   style;
    int unsigned style_left, held_for, tick;
    style      = RX_OPEN;
    style_left = 0;
    held_for   = 0;
    tick       = 0;
    forever begin
      @(negedge clk);
      tick++;
      if (holds_granted != holds_asked) begin
        holds_granted++;
        held_for = LONG_HOLD;
      end
      if (held_for != 0) begin
        held_for--;
        out_ready = 1'b0;
      end else begin
        if (style_left == 0) begin
          style      = rx_style_t'($urandom_range(0, 2));
          style_left = $urandom_range(16, 96);
        end
        style_left--;
        case (style)
          RX_OPEN: out_ready = 1'b1;
          RX_COIN: out_ready = 1'($urandom_range(0, 1));
          default: out_ready = (tick % 4) != 0;
        endcase
      end
    end
  end

  initial begin : stimulus
    step_t       directed [$];
    int unsigned rand_words, phase, sprite_words, read_pct, ox, len, oy, k;
    bit          fresh;

    // hold reset, then release at a falling edge
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed table. Starts from the reset registers: 4-bit, length 1, full stride.
    //                            kind       reg             val   rst   pix    addr       k     want
    directed.push_back(mk_step(STEP_READ, REG_DEPTH_MODE, 0,    1'b0, 8'h00, 18'h00000, 1'b1, 8'h00));
    directed.push_back(mk_step(STEP_READ, REG_DEPTH_MODE, 0,    1'b0, 8'h00, 18'h3ffff, 1'b1, 8'h00));
    directed.push_back(mk_step(STEP_PLOT, REG_DEPTH_MODE, 0,    1'b1, 8'hff, 18'h00000, 1'b0, 8'h00));
    directed.push_back(mk_step(STEP_PLOT, REG_DEPTH_MODE, 0,    1'b0, 8'ha5, 18'h00000, 1'b0, 8'h00));
    // restart on a read must leave the position alone
    directed.push_back(mk_step(STEP_READ, REG_DEPTH_MODE, 0,    1'b1, 8'h00, 18'h00000, 1'b0, 8'h00));
    directed.push_back(mk_step(STEP_PLOT, REG_DEPTH_MODE, 0,    1'b0, 8'h3c, 18'h00000, 1'b0, 8'h00));
    directed.push_back(mk_step(STEP_READ, REG_DEPTH_MODE, 0,    1'b0, 8'h00, 18'd1024,  1'b0, 8'h00));
    directed.push_back(mk_step(STEP_READ, REG_DEPTH_MODE, 0,    1'b0, 8'h00, 18'd2048,  1'b0, 8'h00));
    // odd origin fills the high nibble; zero length and zero pages clamp up;
    // the second pixel falls below the last row
    directed.push_back(mk_step(STEP_CFG,  REG_ORIGIN_X,   255,  1'b0, 8'h00, 18'h00000, 1'b0, 8'h00));
    directed.push_back(mk_step(STEP_CFG,  REG_ORIGIN_Y,   255,  1'b0, 8'h00, 18'h00000, 1'b0, 8'h00));
    directed.push_back(mk_step(STEP_CFG,  REG_ROW_LEN,    0,    1'b0, 8'h00, 18'h00000, 1'b0, 8'h00));
    directed.push_back(mk_step(STEP_CFG,  REG_PAGE_COLS,  0,    1'b0, 8'h00, 18'h00000, 1'b0, 8'h00));
    directed.push_back(mk_step(STEP_PLOT, REG_DEPTH_MODE, 0,    1'b1, 8'h0b, 18'h00000, 1'b0, 8'h00));
    directed.push_back(mk_step(STEP_PLOT, REG_DEPTH_MODE, 0,    1'b0, 8'h07, 18'h00000, 1'b0, 8'h00));
    directed.push_back(mk_step(STEP_READ, REG_DEPTH_MODE, 0,    1'b0, 8'h00, 18'd32767, 1'b0, 8'h00));
    // 8-bit rotated with oversized length and page count: the pixel lands off memory
    directed.push_back(mk_step(STEP_CFG,  REG_DEPTH_MODE, 1,    1'b0, 8'h00, 18'h00000, 1'b0, 8'h00));
    directed.push_back(mk_step(STEP_CFG,  REG_ROTATE,     1,    1'b0, 8'h00, 18'h00000, 1'b0, 8'h00));
    directed.push_back(mk_step(STEP_CFG,  REG_ORIGIN_X,   2047, 1'b0, 8'h00, 18'h00000, 1'b0, 8'h00));
    directed.push_back(mk_step(STEP_CFG,  REG_ORIGIN_Y,   0,    1'b0, 8'h00, 18'h00000, 1'b0, 8'h00));
    directed.push_back(mk_step(STEP_CFG,  REG_ROW_LEN,    4095, 1'b0, 8'h00, 18'h00000, 1'b0, 8'h00));
    directed.push_back(mk_step(STEP_CFG,  REG_PAGE_COLS,  15,   1'b0, 8'h00, 18'h00000, 1'b0, 8'h00));
    directed.push_back(mk_step(STEP_PLOT, REG_DEPTH_MODE, 0,    1'b1, 8'h5a, 18'h00000, 1'b0, 8'h00));
    directed.push_back(mk_step(STEP_READ, REG_DEPTH_MODE, 0,    1'b0, 8'h00, 18'd1023,  1'b0, 8'h00));
    // rotated sprite whose row length shrinks after three pixels
    directed.push_back(mk_step(STEP_CFG,  REG_ORIGIN_X,   0,    1'b0, 8'h00, 18'h00000, 1'b0, 8'h00));
    directed.push_back(mk_step(STEP_CFG,  REG_ROW_LEN,    4,    1'b0, 8'h00, 18'h00000, 1'b0, 8'h00));
    directed.push_back(mk_step(STEP_CFG,  REG_PAGE_COLS,  8,    1'b0, 8'h00, 18'h00000, 1'b0, 8'h00));
    directed.push_back(mk_step(STEP_PLOT, REG_DEPTH_MODE, 0,    1'b1, 8'h11, 18'h00000, 1'b0, 8'h00));
    directed.push_back(mk_step(STEP_PLOT, REG_DEPTH_MODE, 0,    1'b0, 8'h22, 18'h00000, 1'b0, 8'h00));
    directed.push_back(mk_step(STEP_PLOT, REG_DEPTH_MODE, 0,    1'b0, 8'h33, 18'h00000, 1'b0, 8'h00));
    directed.push_back(mk_step(STEP_CFG,  REG_ROW_LEN,    2,    1'b0, 8'h00, 18'h00000, 1'b0, 8'h00));
    directed.push_back(mk_step(STEP_PLOT, REG_DEPTH_MODE, 0,    1'b0, 8'h44, 18'h00000, 1'b0, 8'h00));
    directed.push_back(mk_step(STEP_PLOT, REG_DEPTH_MODE, 0,    1'b0, 8'h55, 18'h00000, 1'b0, 8'h00));
    directed.push_back(mk_step(STEP_READ, REG_DEPTH_MODE, 0,    1'b0, 8'h00, 18'd1025,  1'b0, 8'h00));
    directed.push_back(mk_step(STEP_READ, REG_DEPTH_MODE, 0,    1'b0, 8'h00, 18'd3072,  1'b0, 8'h00));
    directed.push_back(mk_step(STEP_READ, REG_DEPTH_MODE, 0,    1'b0, 8'h00, 18'd2048,  1'b0, 8'h00));
    // 4-bit at the far right origin with one page: off the right edge
    directed.push_back(mk_step(STEP_CFG,  REG_DEPTH_MODE, 0,    1'b0, 8'h00, 18'h00000, 1'b0, 8'h00));
    directed.push_back(mk_step(STEP_CFG,  REG_ROTATE,     0,    1'b0, 8'h00, 18'h00000, 1'b0, 8'h00));
    directed.push_back(mk_step(STEP_CFG,  REG_ORIGIN_X,   2047, 1'b0, 8'h00, 18'h00000, 1'b0, 8'h00));
    directed.push_back(mk_step(STEP_CFG,  REG_ROW_LEN,    2048, 1'b0, 8'h00, 18'h00000, 1'b0, 8'h00));
    directed.push_back(mk_step(STEP_CFG,  REG_PAGE_COLS,  1,    1'b0, 8'h00, 18'h00000, 1'b0, 8'h00));
    directed.push_back(mk_step(STEP_PLOT, REG_DEPTH_MODE, 0,    1'b1, 8'hf0, 18'h00000, 1'b0, 8'h00));
    directed.push_back(mk_step(STEP_READ, REG_DEPTH_MODE, 0,    1'b0, 8'h00, 18'h3ffff, 1'b0, 8'h00));

    // walk the table; no gaps on the sender here
    gap_max = 0;
    foreach (directed[i]) begin
      case (directed[i].kind)
        STEP_CFG: begin
          settle();
          write_reg(directed[i].reg_idx, directed[i].reg_val);
        end
        STEP_PLOT: offer_word(OP_PLOT, directed[i].restart, directed[i].pix, directed[i].addr,
                              1'b0, 8'h00);
        default:   offer_word(OP_READ, directed[i].restart, directed[i].pix, directed[i].addr,
                              directed[i].known, directed[i].want);
      endcase
    end

    // Random sprites. Each phase drains, picks new registers, then streams one sprite
    // with reads mixed in; a few phases skip the restart or throw one in mid-sprite.
    rand_words = 0;
    phase      = 0;
    while (rand_words < RANDOM_WORDS) begin
      settle();
      case ($urandom_range(0, 9))
        0:       ox = 0;
        1:       ox = 2047;
        default: ox = $urandom_range(0, 240);
      endcase
      case ($urandom_range(0, 9))
        0:       len = 0;
        1:       len = 4095;
        2:       len = 2048;
        default: len = $urandom_range(1, 12);
      endcase
      case ($urandom_range(0, 7))
        0:       oy = 0;
        1:       oy = 255;
        default: oy = $urandom_range(0, 200);
      endcase
      write_reg(REG_DEPTH_MODE, $urandom_range(0, 1));
      write_reg(REG_ROTATE, ($urandom_range(0, 3) == 0) ? 1 : 0);
      write_reg(REG_ORIGIN_X, ox);
      write_reg(REG_ORIGIN_Y, oy);
      write_reg(REG_ROW_LEN, len);
      write_reg(REG_PAGE_COLS, $urandom_range(0, 15));

      gap_max      = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      read_pct     = 30;
      sprite_words = $urandom_range(8, 80);
      fresh        = $urandom_range(0, 6) != 0;
      // now and then stall the result side hard and keep reads coming, so the
      // output backs up into the pipeline and closes the input
      if (phase % 8 == 2) begin
        holds_asked++;
        gap_max      = 0;
        read_pct     = 70;
        sprite_words = 80;
      end
      for (k = 0; k < sprite_words; k++) begin
        if ($urandom_range(0, 99) < read_pct)
          offer_word(OP_READ, 1'($urandom_range(0, 1)), PIX_W'($urandom_range(0, 255)),
                     pick_read_address(), 1'b0, 8'h00);
        else
          offer_word(OP_PLOT, (k == 0 && fresh) || $urandom_range(0, 39) == 0,
                     PIX_W'($urandom_range(0, 255)), RADDR_W'($urandom_range(0, MEM_BYTES - 1)),
                     1'b0, 8'h00);
      end
      rand_words += sprite_words;
      phase++;
    end

    // drain the last results and let the pipeline go quiet
    settle();
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
